// ----- rtl/aiop_pkg.sv -----
// Shared types and codes for the arcade I/O port board with barrel shifter.
package aiop_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] PORT_0 = 3'd0;
    localparam logic [2:0] PORT_1 = 3'd1;
    localparam logic [2:0] PORT_2 = 3'd2;
    localparam logic [2:0] PORT_3 = 3'd3;
    localparam logic [2:0] PORT_4 = 3'd4;
    localparam logic [2:0] PORT_5 = 3'd5;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned SHIFT_W = 16;
    localparam int unsigned AMT_W   = 3;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned MASK_W  = 9;

    typedef struct packed {
        logic               op;
        logic [2:0]         port;
        logic [DATA_W-1:0]  write_data;
        logic               coin;
        logic               start_one;
        logic               start_two;
        logic               fire;
        logic               move_left;
        logic               move_right;
        logic               tilt_switch;
        logic [STAMP_W-1:0] time_stamp;
    } t_item;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift_word;
        logic [AMT_W-1:0]   shift_amount;
        logic [DATA_W-1:0]  last_sound_a;
        logic [DATA_W-1:0]  last_sound_b;
        logic               mute_flag;
        logic               red_flag;
        logic               flip_flag;
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [MASK_W-1:0]  sound_start_mask;
        logic               sound_stop;
        logic               mute_level;
        logic               screen_red_level;
        logic               flip_level;
        logic               speaker_event;
        logic               speaker_level;
        logic [STAMP_W-1:0] speaker_time;
    } t_result;

endpackage

// ----- rtl/aiop_port_logic.sv -----
// Port decode, read mux, shifter window and sound edge detection for one transaction.
module aiop_port_logic (
    input  logic [aiop_pkg::DATA_W-1:0] i_dip,
    input  aiop_pkg::t_state            i_state,
    input  aiop_pkg::t_item             i_item,
    output aiop_pkg::t_state            o_state,
    output aiop_pkg::t_result           o_result
);
    import aiop_pkg::*;

    logic [DATA_W-1:0]  rise_a;
    logic [DATA_W-1:0]  rise_b;
    logic [DATA_W-1:0]  fall_b;
    logic [SHIFT_W-1:0] window;
    logic [AMT_W:0]     rsh;

    always_comb begin
        rise_a = i_item.write_data & ~i_state.last_sound_a;
        rise_b = i_item.write_data & ~i_state.last_sound_b;
        fall_b = ~i_item.write_data & i_state.last_sound_b;
        rsh    = (AMT_W+1)'(DATA_W) - {1'b0, i_state.shift_amount};
        window = i_state.shift_word >> rsh;

        o_state  = i_state;
        o_result = '0;

        if (i_item.op == OP_READ) begin
            case (i_item.port)
                PORT_0: o_result.read_data = '1;
                PORT_1: o_result.read_data = {1'b1, i_item.move_right, i_item.move_left,
                                              i_item.fire, 1'b1, i_item.start_one,
                                              i_item.start_two, i_item.coin};
                PORT_2: o_result.read_data = {~i_dip[7], i_item.move_right,
                                              i_item.move_left, i_item.fire, ~i_dip[3],
                                              i_item.tilt_switch, ~i_dip[1], ~i_dip[0]};
                PORT_3: o_result.read_data = window[DATA_W-1:0];
                default: o_result.read_data = '0;
            endcase
        end else begin
            case (i_item.port)
                PORT_2: o_state.shift_amount = i_item.write_data[AMT_W-1:0];
                PORT_3: begin
                    o_result.sound_start_mask[4:0] = rise_a[4:0];
                    o_state.red_flag     = i_item.write_data[2];
                    o_state.mute_flag    = ~i_item.write_data[5];
                    o_state.last_sound_a = i_item.write_data;
                end
                PORT_4: o_state.shift_word = {i_item.write_data,
                                              i_state.shift_word[SHIFT_W-1:DATA_W]};
                PORT_5: begin
                    o_result.sound_start_mask[7:5] = rise_b[2:0];
                    o_result.sound_start_mask[8]   = rise_b[4];
                    o_result.sound_stop    = fall_b[4];
                    o_result.speaker_event = 1'b1;
                    o_result.speaker_level = i_item.write_data[3];
                    o_result.speaker_time  = i_item.time_stamp;
                    o_state.flip_flag    = i_item.write_data[5];
                    o_state.last_sound_b = i_item.write_data;
                end
                default: ;
            endcase
        end

        o_result.mute_level       = o_state.mute_flag;
        o_result.screen_red_level = o_state.red_flag;
        o_result.flip_level       = o_state.flip_flag;
    end

endmodule

// ----- rtl/arcade_io_ports_with_shifter.sv -----
// Top level of the arcade I/O port board with barrel shifter.
// One port access per transaction, one result per transaction. A transaction
// is held in an input register, decoded combinationally and applied to the
// shifter and sound latches, and its result lands in an output register; a
// new transaction can be taken every cycle while the result side keeps up,
// and a stall on the result side backs up through the two register stages
// to o_ready. The DIP register is written with i_cfg_we.
module arcade_io_ports_with_shifter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aiop_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [2:0]                     i_port,
    input  logic [aiop_pkg::DATA_W-1:0]    i_write_data,
    input  logic                           i_coin,
    input  logic                           i_start_one,
    input  logic                           i_start_two,
    input  logic                           i_fire,
    input  logic                           i_move_left,
    input  logic                           i_move_right,
    input  logic                           i_tilt_switch,
    input  logic [aiop_pkg::STAMP_W-1:0]   i_time_stamp,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [aiop_pkg::DATA_W-1:0]    o_read_data,
    output logic [aiop_pkg::MASK_W-1:0]    o_sound_start_mask,
    output logic                           o_sound_stop,
    output logic                           o_mute_level,
    output logic                           o_screen_red_level,
    output logic                           o_flip_level,
    output logic                           o_speaker_event,
    output logic                           o_speaker_level,
    output logic [aiop_pkg::STAMP_W-1:0]   o_speaker_time
);
    import aiop_pkg::*;

    logic [DATA_W-1:0] r_dip;
    t_item             r_item;
    logic              r_item_valid;
    t_state            r_state;
    t_state            n_state;
    t_result           r_out;
    t_result           n_out;
    logic              r_out_valid;
    logic              advance;

    assign advance = r_item_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_item_valid || advance;

    aiop_port_logic u_port_logic (
        .i_dip    (r_dip),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip        <= '0;
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dip <= i_cfg_data;
            end
            if (o_ready) begin
                r_item_valid <= i_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= '{op:          i_op,
                        port:        i_port,
                        write_data:  i_write_data,
                        coin:        i_coin,
                        start_one:   i_start_one,
                        start_two:   i_start_two,
                        fire:        i_fire,
                        move_left:   i_move_left,
                        move_right:  i_move_right,
                        tilt_switch: i_tilt_switch,
                        time_stamp:  i_time_stamp};
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_read_data        = r_out.read_data;
    assign o_sound_start_mask = r_out.sound_start_mask;
    assign o_sound_stop       = r_out.sound_stop;
    assign o_mute_level       = r_out.mute_level;
    assign o_screen_red_level = r_out.screen_red_level;
    assign o_flip_level       = r_out.flip_level;
    assign o_speaker_event    = r_out.speaker_event;
    assign o_speaker_level    = r_out.speaker_level;
    assign o_speaker_time     = r_out.speaker_time;

endmodule
